FILE: rtl/mes_pkg.sv
// Shared types and constants of the maze exploration step block.
// Used by every rtl file but mes_div; depends on nothing.
`timescale 1ns / 1ps
package mes_pkg;

   localparam int DIST_W    = 12;
   localparam int CFG_W     = 12;
   localparam int CFG_IDX_W = 3;
   localparam int ACT_W     = 2;
   localparam int POS_W     = 4;
   localparam int DIR_W     = 2;
   localparam int ADV_W     = 13;
   localparam int PROD_W    = DIST_W + ADV_W;
   localparam int WALL_W    = 4;

   localparam int DEF_COLUMNS = 16;
   localparam int DEF_ROWS    = 16;

   localparam logic [ADV_W-1:0] ADV_MAX = '1;

   // register indexes
   localparam logic [CFG_IDX_W-1:0] REG_WALL_THRESHOLD = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE      = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_FORWARD_STEP   = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_OPEN_DISTANCE  = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT    = 3'd4;

   localparam logic [CFG_W-1:0] RST_WALL_THRESHOLD = 12'd100;
   localparam logic [CFG_W-1:0] RST_CELL_SIZE      = 12'd180;
   localparam logic [CFG_W-1:0] RST_FORWARD_STEP   = 12'd20;
   localparam logic [CFG_W-1:0] RST_OPEN_DISTANCE  = 12'd1260;
   localparam logic [CFG_W-1:0] RST_COUNT_LIMIT    = 12'd1266;

   // action codes
   localparam logic [ACT_W-1:0] ACT_FORWARD = 2'd0;
   localparam logic [ACT_W-1:0] ACT_LEFT    = 2'd1;
   localparam logic [ACT_W-1:0] ACT_RIGHT   = 2'd2;
   localparam logic [ACT_W-1:0] ACT_AROUND  = 2'd3;

   // absolute directions
   localparam logic [DIR_W-1:0] DIR_NORTH = 2'd0;
   localparam logic [DIR_W-1:0] DIR_EAST  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_SOUTH = 2'd2;
   localparam logic [DIR_W-1:0] DIR_WEST  = 2'd3;

   typedef struct packed {
      logic load_in;
      logic clear_step;
      logic div_front;
      logic div_dist;
      logic cap_counts;
      logic adv_drop;
      logic adv_dist;
      logic last_upd;
      logic adv_inc;
      logic adv_clr;
      logic mark_vis;
      logic wall_own;
      logic wall_nb;
      logic mul;
      logic rd_left;
      logic rd_right;
      logic cap_right;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic div_busy;
      logic counts_lt;
      logic br_open;
      logic br_mid;
      logic adv_nz;
      logic dist_gt;
      logic out_free;
   } sts_type;

endpackage

FILE: rtl/mes_if.sv
// Channel interfaces of the maze exploration step block: sample words in,
// decision words out. Depends on mes_pkg.
`timescale 1ns / 1ps
interface mes_req_if;
   logic                        valid;
   logic                        ready;
   logic [mes_pkg::DIST_W-1:0]  front_distance;
   logic [mes_pkg::DIST_W-1:0]  left_distance;
   logic [mes_pkg::DIST_W-1:0]  right_distance;
   modport source (output valid, front_distance, left_distance, right_distance,
                   input ready);
   modport sink   (input valid, front_distance, left_distance, right_distance,
                   output ready);
endinterface

interface mes_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mes_pkg::ACT_W-1:0]   action;
   logic                        stop_first;
   logic [mes_pkg::POS_W-1:0]   pos_x;
   logic [mes_pkg::POS_W-1:0]   pos_y;
   logic [mes_pkg::DIR_W-1:0]   heading;
   modport source (output valid, action, stop_first, pos_x, pos_y, heading,
                   input ready);
   modport sink   (input valid, action, stop_first, pos_x, pos_y, heading,
                   output ready);
endinterface

FILE: rtl/mes_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps
module mes_div #(
   parameter int N = 25,
   parameter int D = 12
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [N-1:0] dividend,
   input  logic [D-1:0] divisor,
   output logic         busy,
   output logic [N-1:0] quotient
);
   localparam int CW = $clog2(N + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [N-1:0]  q_ff, q_in;
   logic [D-1:0]  r_ff, r_in;
   logic [D-1:0]  d_ff, d_in;
   logic [D:0]    shifted;
   logic          ge;

   always_comb begin
      shifted = {r_ff, q_ff[N-1]};
      ge      = shifted >= {1'b0, d_ff};
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      if (start) begin
         cnt_in = CW'(N);
         q_in   = dividend;
         r_in   = '0;
         d_in   = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CW'(1);
         q_in   = {q_ff[N-2:0], ge};
         r_in   = ge ? D'(shifted - {1'b0, d_ff}) : D'(shifted);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign busy     = cnt_ff != '0;
   assign quotient = q_ff;
endmodule

FILE: rtl/mes_ctrl.sv
// Sequencer of the maze exploration step: walks each sample word through
// divide, map update and decision. Depends on mes_pkg.
`timescale 1ns / 1ps
module mes_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mes_pkg::sts_type sts,
   output mes_pkg::cmd_type cmd
);
   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_FDIV_GO, ST_FDIV_WAIT, ST_CMP,
      ST_D_VIS, ST_D_WOWN, ST_D_WNB, ST_BR,
      ST_S_WOWN, ST_S_WNB, ST_MUL, ST_CHK, ST_DDIV_GO, ST_DDIV_WAIT,
      ST_R_VIS, ST_R_WOWN, ST_R_WNB, ST_RDL, ST_RDR, ST_CAPR, ST_FIN
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_FDIV_GO;
            end
         end
         ST_FDIV_GO: begin
            cmd.div_front = 1'b1;
            state_in      = ST_FDIV_WAIT;
         end
         ST_FDIV_WAIT: begin
            if (!sts.div_busy) begin
               cmd.cap_counts = 1'b1;
               state_in       = ST_CMP;
            end
         end
         ST_CMP: begin
            if (sts.counts_lt) begin
               cmd.adv_drop = 1'b1;
               state_in     = ST_D_VIS;
            end else begin
               state_in = ST_BR;
            end
         end
         ST_D_VIS: begin
            cmd.mark_vis = 1'b1;
            state_in     = ST_D_WOWN;
         end
         ST_D_WOWN: begin
            cmd.wall_own = 1'b1;
            state_in     = ST_D_WNB;
         end
         ST_D_WNB: begin
            cmd.wall_nb = 1'b1;
            state_in    = ST_BR;
         end
         ST_BR: begin
            cmd.last_upd = 1'b1;
            if (sts.br_open) begin
               cmd.adv_inc = 1'b1;
               state_in    = ST_MUL;
            end else if (sts.br_mid) begin
               state_in = sts.adv_nz ? ST_MUL : ST_RDL;
            end else begin
               state_in = ST_S_WOWN;
            end
         end
         ST_S_WOWN: begin
            cmd.wall_own = 1'b1;
            state_in     = ST_S_WNB;
         end
         ST_S_WNB: begin
            cmd.wall_nb = 1'b1;
            state_in    = ST_RDL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (sts.dist_gt) state_in = ST_DDIV_GO;
            else             state_in = sts.br_open ? ST_FIN : ST_RDL;
         end
         ST_DDIV_GO: begin
            cmd.div_dist = 1'b1;
            state_in     = ST_DDIV_WAIT;
         end
         ST_DDIV_WAIT: begin
            if (!sts.div_busy) begin
               cmd.adv_dist = 1'b1;
               state_in     = ST_R_VIS;
            end
         end
         ST_R_VIS: begin
            cmd.mark_vis = 1'b1;
            cmd.adv_clr  = 1'b1;
            state_in     = ST_R_WOWN;
         end
         ST_R_WOWN: begin
            cmd.wall_own = 1'b1;
            state_in     = ST_R_WNB;
         end
         ST_R_WNB: begin
            cmd.wall_nb = 1'b1;
            state_in    = sts.br_open ? ST_FIN : ST_RDL;
         end
         ST_RDL: begin
            cmd.rd_left = 1'b1;
            state_in    = ST_RDR;
         end
         ST_RDR: begin
            cmd.rd_right = 1'b1;
            state_in     = ST_CAPR;
         end
         ST_CAPR: begin
            cmd.cap_right = 1'b1;
            state_in      = ST_FIN;
         end
         ST_FIN: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
endmodule

FILE: rtl/mes_dp.sv
// Datapath of the maze exploration step: registers, maps, divider, output word.
// Depends on mes_pkg, mes_if and mes_div.
`timescale 1ns / 1ps
module mes_dp #(
   parameter int COLS = mes_pkg::DEF_COLUMNS,
   parameter int ROWS = mes_pkg::DEF_ROWS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [mes_pkg::CFG_IDX_W-1:0] csr_index,
   input  logic [mes_pkg::CFG_W-1:0]     csr_wdata,
   input  logic [mes_pkg::DIST_W-1:0]    front_distance,
   input  logic [mes_pkg::DIST_W-1:0]    left_distance,
   input  logic [mes_pkg::DIST_W-1:0]    right_distance,
   input  mes_pkg::cmd_type              cmd,
   output mes_pkg::sts_type              sts,
   mes_rsp_if.source                     rsp_if
);
   localparam int XW     = $clog2(COLS);
   localparam int YW     = $clog2(ROWS);
   localparam int CELLS  = COLS * ROWS;
   localparam int AW     = $clog2(CELLS);
   localparam int DW     = mes_pkg::DIST_W;
   localparam int PW     = mes_pkg::PROD_W;
   localparam int WW     = mes_pkg::WALL_W;

   typedef struct packed {
      logic          ok;
      logic [XW-1:0] x;
      logic [YW-1:0] y;
   } nb_type;

   function automatic nb_type neighbour(logic [XW-1:0] x, logic [YW-1:0] y,
                                        logic [mes_pkg::DIR_W-1:0] d);
      nb_type n;
      n.ok = 1'b1;
      n.x  = x;
      n.y  = y;
      case (d)
         mes_pkg::DIR_NORTH: if (y == YW'(ROWS - 1)) n.ok = 1'b0; else n.y = y + YW'(1);
         mes_pkg::DIR_EAST:  if (x == XW'(COLS - 1)) n.ok = 1'b0; else n.x = x + XW'(1);
         mes_pkg::DIR_SOUTH: if (y == '0) n.ok = 1'b0; else n.y = y - YW'(1);
         default:            if (x == '0) n.ok = 1'b0; else n.x = x - XW'(1);
      endcase
      return n;
   endfunction

   function automatic logic [AW-1:0] cell_addr(logic [XW-1:0] x, logic [YW-1:0] y);
      return AW'(AW'(y) * AW'(COLS) + AW'(x));
   endfunction

   // configuration
   logic [DW-1:0] wt_ff, cs_ff, fs_ff, od_ff, cl_ff;
   // sample word
   logic [DW-1:0] ff_ff, fl_ff, fr_ff;
   // robot state
   logic [XW-1:0] pos_x_ff;
   logic [YW-1:0] pos_y_ff;
   logic [mes_pkg::DIR_W-1:0] dir_ff;
   logic [DW-1:0] last_ff, counts_ff;
   logic [mes_pkg::ADV_W-1:0] adv_ff;
   logic [PW-1:0] prod_ff;
   logic          lv_ff, rv_ff, rd_vis_ff, rd_ok_ff;
   logic [AW-1:0] clr_addr_ff;
   // maps
   logic          visited_mem [CELLS];
   logic [WW-1:0] wall_mem    [CELLS];
   // output word
   logic                        rsp_valid_ff;
   logic [mes_pkg::ACT_W-1:0]   act_ff;
   logic                        stop_ff;
   logic [mes_pkg::POS_W-1:0]   out_x_ff, out_y_ff;
   logic [mes_pkg::DIR_W-1:0]   out_dir_ff;

   logic [DW-1:0] cs_eff;
   logic          fw, rw, lw, br_open, br_mid;
   logic          div_start, div_busy;
   logic [PW-1:0] div_q, cells;
   logic [XW-1:0] x_adv;
   logic [YW-1:0] y_adv;
   nb_type        nb_front, nb_rd;
   logic [AW-1:0] own_addr, rd_addr, vis_addr, wall_addr;
   logic          vis_we, vis_data, wall_we;
   logic [WW-1:0] wall_mask, wall_data, own_mask, own_data;
   logic [mes_pkg::DIR_W-1:0] rel, nb_bit;
   logic          lo, ro;
   logic [mes_pkg::ACT_W-1:0] side, act;
   logic [mes_pkg::DIR_W-1:0] dir_new;

   assign cs_eff  = (cs_ff == '0) ? DW'(1) : cs_ff;
   assign fw      = ff_ff <= wt_ff;
   assign rw      = fr_ff <= wt_ff;
   assign lw      = fl_ff <= wt_ff;
   assign br_open = ff_ff >= od_ff;
   assign br_mid  = ff_ff > wt_ff;

   assign div_start = cmd.div_front | cmd.div_dist;

   mes_div #(.N(PW), .D(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cmd.div_front ? PW'(ff_ff) : prod_ff),
      .divisor  (cs_eff),
      .busy     (div_busy),
      .quotient (div_q)
   );

   // saturating move along the heading
   always_comb begin
      cells = cmd.adv_drop ? PW'(1) : div_q;
      x_adv = pos_x_ff;
      y_adv = pos_y_ff;
      case (dir_ff)
         mes_pkg::DIR_NORTH:
            y_adv = (cells >= PW'(ROWS - 1) - PW'(pos_y_ff)) ? YW'(ROWS - 1)
                                                             : YW'(PW'(pos_y_ff) + cells);
         mes_pkg::DIR_EAST:
            x_adv = (cells >= PW'(COLS - 1) - PW'(pos_x_ff)) ? XW'(COLS - 1)
                                                             : XW'(PW'(pos_x_ff) + cells);
         mes_pkg::DIR_SOUTH:
            y_adv = (cells >= PW'(pos_y_ff)) ? '0 : YW'(PW'(pos_y_ff) - cells);
         default:
            x_adv = (cells >= PW'(pos_x_ff)) ? '0 : XW'(PW'(pos_x_ff) - cells);
      endcase
   end

   // map addressing and write data
   always_comb begin
      own_addr = cell_addr(pos_x_ff, pos_y_ff);
      nb_front = neighbour(pos_x_ff, pos_y_ff, dir_ff);
      nb_rd    = neighbour(pos_x_ff, pos_y_ff,
                           cmd.rd_left ? dir_ff + 2'd3 : dir_ff + 2'd1);
      rd_addr  = cell_addr(nb_rd.x, nb_rd.y);
      nb_bit   = dir_ff + 2'd2;
      for (int b = 0; b < WW; b++) begin
         rel = 2'(b) - dir_ff;
         case (rel)
            2'd0:    begin own_mask[b] = 1'b1; own_data[b] = fw; end
            2'd1:    begin own_mask[b] = 1'b1; own_data[b] = rw; end
            2'd3:    begin own_mask[b] = 1'b1; own_data[b] = lw; end
            default: begin own_mask[b] = 1'b0; own_data[b] = 1'b0; end
         endcase
      end
      vis_we   = cmd.clear_step | cmd.mark_vis;
      vis_addr = cmd.clear_step ? clr_addr_ff : own_addr;
      vis_data = cmd.clear_step ? (clr_addr_ff == '0) : 1'b1;
      wall_we  = cmd.clear_step | cmd.wall_own | (cmd.wall_nb & nb_front.ok);
      if (cmd.clear_step) begin
         wall_addr = clr_addr_ff;
         wall_mask = '1;
         wall_data = '1;
      end else if (cmd.wall_own) begin
         wall_addr = own_addr;
         wall_mask = own_mask;
         wall_data = own_data;
      end else begin
         wall_addr = cell_addr(nb_front.x, nb_front.y);
         wall_mask = WW'(1) << nb_bit;
         wall_data = {WW{fw}};
      end
   end

   always_ff @(posedge clock) begin
      if (vis_we) visited_mem[vis_addr] <= vis_data;
      if (cmd.rd_left | cmd.rd_right) rd_vis_ff <= visited_mem[rd_addr];
      for (int b = 0; b < WW; b++) begin
         if (wall_we && wall_mask[b]) wall_mem[wall_addr][b] <= wall_data[b];
      end
   end

   // side choice: unvisited open side first, else the longer one
   always_comb begin
      lo = fl_ff > wt_ff;
      ro = fr_ff > wt_ff;
      if (lo && ro) begin
         if (!lv_ff && rv_ff)      side = mes_pkg::ACT_LEFT;
         else if (lv_ff && !rv_ff) side = mes_pkg::ACT_RIGHT;
         else side = (fl_ff > fr_ff) ? mes_pkg::ACT_LEFT : mes_pkg::ACT_RIGHT;
      end else if (lo) begin
         side = mes_pkg::ACT_LEFT;
      end else if (ro) begin
         side = mes_pkg::ACT_RIGHT;
      end else begin
         side = mes_pkg::ACT_FORWARD;
      end
      if (br_open)     act = mes_pkg::ACT_FORWARD;
      else if (br_mid) act = side;
      else act = (side == mes_pkg::ACT_FORWARD) ? mes_pkg::ACT_AROUND : side;
      case (act)
         mes_pkg::ACT_LEFT:  dir_new = dir_ff + 2'd3;
         mes_pkg::ACT_RIGHT: dir_new = dir_ff + 2'd1;
         mes_pkg::ACT_AROUND: dir_new = dir_ff + 2'd2;
         default:            dir_new = dir_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wt_ff        <= mes_pkg::RST_WALL_THRESHOLD;
         cs_ff        <= mes_pkg::RST_CELL_SIZE;
         fs_ff        <= mes_pkg::RST_FORWARD_STEP;
         od_ff        <= mes_pkg::RST_OPEN_DISTANCE;
         cl_ff        <= mes_pkg::RST_COUNT_LIMIT;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         dir_ff       <= mes_pkg::DIR_NORTH;
         last_ff      <= '0;
         adv_ff       <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               mes_pkg::REG_WALL_THRESHOLD: wt_ff <= csr_wdata;
               mes_pkg::REG_CELL_SIZE:      cs_ff <= csr_wdata;
               mes_pkg::REG_FORWARD_STEP:   fs_ff <= csr_wdata;
               mes_pkg::REG_OPEN_DISTANCE:  od_ff <= csr_wdata;
               mes_pkg::REG_COUNT_LIMIT:    cl_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.clear_step) clr_addr_ff <= clr_addr_ff + AW'(1);
         if (cmd.adv_drop | cmd.adv_dist) begin
            pos_x_ff <= x_adv;
            pos_y_ff <= y_adv;
         end
         if (cmd.last_upd) last_ff <= counts_ff;
         if (cmd.adv_inc && adv_ff != mes_pkg::ADV_MAX) adv_ff <= adv_ff + 13'd1;
         else if (cmd.adv_clr) adv_ff <= '0;
         if (cmd.finish) begin
            dir_ff       <= dir_new;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (cmd.load_in) begin
         ff_ff <= front_distance;
         fl_ff <= left_distance;
         fr_ff <= right_distance;
      end
      if (cmd.cap_counts) counts_ff <= (ff_ff <= cl_ff) ? div_q[DW-1:0] : '0;
      if (cmd.mul) prod_ff <= PW'(fs_ff) * PW'(adv_ff);
      if (cmd.rd_left | cmd.rd_right) rd_ok_ff <= nb_rd.ok;
      if (cmd.rd_right) lv_ff <= rd_vis_ff & rd_ok_ff;
      if (cmd.cap_right) rv_ff <= rd_vis_ff & rd_ok_ff;
      if (cmd.finish) begin
         act_ff     <= act;
         stop_ff    <= ~br_open & ~br_mid;
         out_x_ff   <= mes_pkg::POS_W'(pos_x_ff);
         out_y_ff   <= mes_pkg::POS_W'(pos_y_ff);
         out_dir_ff <= dir_new;
      end
   end

   assign sts.clear_last = clr_addr_ff == AW'(CELLS - 1);
   assign sts.div_busy   = div_busy;
   assign sts.counts_lt  = counts_ff < last_ff;
   assign sts.br_open    = br_open;
   assign sts.br_mid     = br_mid;
   assign sts.adv_nz     = adv_ff != '0;
   assign sts.dist_gt    = prod_ff > PW'(cs_eff);
   assign sts.out_free   = ~rsp_valid_ff | rsp_if.ready;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.action     = act_ff;
   assign rsp_if.stop_first = stop_ff;
   assign rsp_if.pos_x      = out_x_ff;
   assign rsp_if.pos_y      = out_y_ff;
   assign rsp_if.heading    = out_dir_ff;

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_if.ready))
      else $error("output word overwritten");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");
   a_pos_grid: assert property (@(posedge clock) disable iff (reset)
      (32'(pos_x_ff) < COLS) && (32'(pos_y_ff) < ROWS))
      else $error("position left the grid");
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |=> rsp_valid_ff)
      else $error("output word dropped");
endmodule

FILE: rtl/maze_explore_step.sv
// Top level of the maze exploration step block: sequencer plus datapath.
// Depends on mes_pkg, mes_if, mes_div, mes_ctrl and mes_dp.
`timescale 1ns / 1ps
// Usage
//   req_if carries one sample word (front, left, right distance in mm); it is
//   taken when valid and ready are both high. rsp_if returns one decision word
//   per sample: action, stop_first, position and heading after the step.
//   csr_we/csr_index/csr_wdata write the five 12-bit settings; write them only
//   while no sample is in flight. Unknown indexes are dropped.
// Sequencing
//   One sample at a time; a new sample is not taken before the result word of the
//   last one is written. The shared 25-step divider runs once for the front cell
//   count and, when dead reckoning moves the robot, once for the travel distance.
//   ready returns with the result.
// Reset
//   Synchronous, active high. After reset the block sweeps both maps, one cell
//   a cycle, with ready low throughout.
// Stall
//   A finished word waits in the output register; the next sample is still
//   accepted and worked on, and holds at the end until the output register
//   frees.
module maze_explore_step #(
   parameter int MAZE_COLUMNS = mes_pkg::DEF_COLUMNS,
   parameter int MAZE_ROWS    = mes_pkg::DEF_ROWS
) (
   input  logic                          clock,
   input  logic                          reset,
   mes_req_if.sink                       req_if,
   mes_rsp_if.source                     rsp_if,
   input  logic                          csr_we,
   input  logic [mes_pkg::CFG_IDX_W-1:0] csr_index,
   input  logic [mes_pkg::CFG_W-1:0]     csr_wdata
);
   mes_pkg::cmd_type cmd;
   mes_pkg::sts_type sts;
   logic             ready;

   // sequencer: one state per map access or arithmetic step
   mes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   assign req_if.ready = ready;

   // datapath: settings, robot state, maps, divider and output register
   mes_dp #(.COLS(MAZE_COLUMNS), .ROWS(MAZE_ROWS)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .front_distance (req_if.front_distance),
      .left_distance  (req_if.left_distance),
      .right_distance (req_if.right_distance),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_if         (rsp_if)
   );
endmodule

FILE: dv/maze_explore_step_tb.sv
// Self-checking bench for maze_explore_step: drives sample words, predicts each
// decision word from a behavioral model of the explorer, and compares them.
// Depends on mes_pkg, mes_if and the RTL of maze_explore_step.
`timescale 1ns / 1ps
module maze_explore_step_tb;

   localparam int COLS = 16;
   localparam int ROWS = 16;
   localparam int NCELL = COLS * ROWS;
   localparam int LIMIT = 1500000;
   localparam logic [mes_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic [mes_pkg::DIST_W-1:0] front;
      logic [mes_pkg::DIST_W-1:0] left;
      logic [mes_pkg::DIST_W-1:0] right;
   } sample_type;

   typedef struct packed {
      logic [mes_pkg::ACT_W-1:0] action;
      logic                      stop_first;
      logic [mes_pkg::POS_W-1:0] pos_x;
      logic [mes_pkg::POS_W-1:0] pos_y;
      logic [mes_pkg::DIR_W-1:0] heading;
   } decision_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [mes_pkg::CFG_IDX_W-1:0] csr_index = '0;
   logic [mes_pkg::CFG_W-1:0] csr_wdata = '0;

   mes_req_if req();
   mes_rsp_if rsp();

   maze_explore_step uut (
      .clock(clock), .reset(reset), .req_if(req.sink), .rsp_if(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---- explorer model state ----
   int unsigned thr, csz, fstep, open_d, climit;
   bit          seen[NCELL];
   logic [3:0]  walls[NCELL];
   int unsigned px, py, dir, last_cells, adv_cnt;

   sample_type   sample_q[$];
   decision_type decision_q[$];
   int  errors = 0;
   int  mismatches = 0;
   int  cycles = 0;
   int unsigned n_pushed = 0;
   bit  calm = 1'b0;     // disable idling on both sides
   bit  hold_tx = 1'b0;  // sender paused by the stimulus thread

   function automatic int unsigned cell_of(int unsigned x, int unsigned y);
      return y * COLS + x;
   endfunction

   // neighbour in absolute direction d; returns 0 outside the grid
   function automatic bit step_to(int unsigned x, int unsigned y, int unsigned d,
                                  output int unsigned nx, output int unsigned ny);
      nx = x;
      ny = y;
      case (d & 3)
         mes_pkg::DIR_NORTH: begin if (y + 1 >= ROWS) return 0; ny = y + 1; end
         mes_pkg::DIR_EAST:  begin if (x + 1 >= COLS) return 0; nx = x + 1; end
         mes_pkg::DIR_SOUTH: begin if (y == 0) return 0; ny = y - 1; end
         default:            begin if (x == 0) return 0; nx = x - 1; end
      endcase
      return 1;
   endfunction

   function automatic void set_wall(int unsigned idx, int unsigned d, bit present);
      walls[idx][d & 3] = present;
   endfunction

   function automatic void mark_walls(bit f, bit r, bit l);
      int unsigned idx, nx, ny;
      idx = cell_of(px, py);
      set_wall(idx, dir, f);
      set_wall(idx, dir + 1, r);
      set_wall(idx, dir + 3, l);
      if (step_to(px, py, dir, nx, ny)) set_wall(cell_of(nx, ny), dir + 2, f);
   endfunction

   // move along heading, saturating at the grid edge
   function automatic void move_cells(int unsigned n);
      case (dir)
         mes_pkg::DIR_NORTH: py = (n >= ROWS - 1 - py) ? ROWS - 1 : py + n;
         mes_pkg::DIR_EAST:  px = (n >= COLS - 1 - px) ? COLS - 1 : px + n;
         mes_pkg::DIR_SOUTH: py = (n >= py) ? 0 : py - n;
         default:            px = (n >= px) ? 0 : px - n;
      endcase
   endfunction

   function automatic bit been_there(int unsigned d);
      int unsigned nx, ny;
      if (!step_to(px, py, d, nx, ny)) return 0;
      return seen[cell_of(nx, ny)];
   endfunction

   function automatic logic [mes_pkg::ACT_W-1:0] pick_side(int unsigned l, int unsigned r);
      bit lo, ro, lv, rv;
      lo = l > thr;
      ro = r > thr;
      if (lo && ro) begin
         lv = been_there(dir + 3);
         rv = been_there(dir + 1);
         if (!lv && rv) return mes_pkg::ACT_LEFT;
         if (lv && !rv) return mes_pkg::ACT_RIGHT;
         return (l > r) ? mes_pkg::ACT_LEFT : mes_pkg::ACT_RIGHT;
      end
      if (lo) return mes_pkg::ACT_LEFT;
      if (ro) return mes_pkg::ACT_RIGHT;
      return mes_pkg::ACT_FORWARD;
   endfunction

   function automatic void reckon(int unsigned cs, bit f, bit r, bit l);
      int unsigned travel;
      travel = fstep * adv_cnt;
      if (travel > cs) begin
         move_cells(travel / cs);
         mark_walls(f, r, l);
         seen[cell_of(px, py)] = 1;
         adv_cnt = 0;
      end
   endfunction

   function automatic decision_type predict_decision(sample_type s);
      int unsigned cs, cells;
      bit fw, rw, lw;
      decision_type d;
      d = '0;
      cs = (csz == 0) ? 1 : csz;
      fw = s.front <= thr;
      rw = s.right <= thr;
      lw = s.left <= thr;
      cells = (s.front <= climit) ? s.front / cs : 0;
      if (cells < last_cells) begin
         move_cells(1);
         seen[cell_of(px, py)] = 1;
         mark_walls(fw, rw, lw);
      end
      last_cells = cells;
      d.action = mes_pkg::ACT_FORWARD;
      if (s.front >= open_d) begin
         if (adv_cnt < mes_pkg::ADV_MAX) adv_cnt++;
         reckon(cs, fw, rw, lw);
      end else if (s.front > thr) begin
         if (adv_cnt > 0) reckon(cs, fw, rw, lw);
         d.action = pick_side(s.left, s.right);
      end else begin
         d.stop_first = 1'b1;
         mark_walls(1, rw, lw);
         d.action = pick_side(s.left, s.right);
         if (d.action == mes_pkg::ACT_FORWARD) d.action = mes_pkg::ACT_AROUND;
      end
      case (d.action)
         mes_pkg::ACT_LEFT:   dir = (dir + 3) & 3;
         mes_pkg::ACT_RIGHT:  dir = (dir + 1) & 3;
         mes_pkg::ACT_AROUND: dir = (dir + 2) & 3;
         default: ;
      endcase
      d.pos_x = px[3:0];
      d.pos_y = py[3:0];
      d.heading = dir[1:0];
      return d;
   endfunction

   // ---- driver: predict at acceptance, then advance the queue ----
   initial begin
      req.valid = 1'b0;
      req.front_distance = '0;
      req.left_distance = '0;
      req.right_distance = '0;
      rsp.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         sample_type nxt;
         bit send;
         if (req.valid && req.ready) begin
            decision_q.push_back(predict_decision(
               {req.front_distance, req.left_distance, req.right_distance}));
            void'(sample_q.pop_front());
         end
         // decide what stands on the channel for the next edge
         send = (sample_q.size() > 0) && !hold_tx
                && (calm || $urandom_range(99) >= 8);
         if (req.valid && !req.ready) begin
            // hold the word until it is taken
         end else if (send) begin
            nxt = sample_q[0];
            req.valid <= 1'b1;
            req.front_distance <= nxt.front;
            req.left_distance <= nxt.left;
            req.right_distance <= nxt.right;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // ---- monitor: compare each taken decision word with the oldest prediction ----
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= calm || $urandom_range(99) >= 8;
         if (rsp.valid && rsp.ready) begin
            decision_type got, want;
            got = {rsp.action, rsp.stop_first, rsp.pos_x, rsp.pos_y, rsp.heading};
            if (decision_q.size() == 0) begin
               errors++;
               if (mismatches++ < 10) $display("unexpected word %p", got);
            end else begin
               want = decision_q.pop_front();
               if (got !== want) begin
                  errors++;
                  if (mismatches++ < 10)
                     $display("mismatch: expected %p actual %p", want, got);
               end
            end
         end
      end
      if (cycles > LIMIT) begin
         $display("maze_explore_step_tb: FAIL");
         $finish;
      end
   end

   // ---- stimulus ----
   task automatic write_reg(logic [mes_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[mes_pkg::CFG_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         mes_pkg::REG_WALL_THRESHOLD: thr = val;
         mes_pkg::REG_CELL_SIZE:      csz = val;
         mes_pkg::REG_FORWARD_STEP:   fstep = val;
         mes_pkg::REG_OPEN_DISTANCE:  open_d = val;
         mes_pkg::REG_COUNT_LIMIT:    climit = val;
         default: ;
      endcase
   endtask

   // wait until every sample went out and every word came back, then settle
   task automatic drain();
      while (sample_q.size() > 0 || decision_q.size() > 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic push(int unsigned f, int unsigned l, int unsigned r);
      sample_type s;
      s.front = f[mes_pkg::DIST_W-1:0];
      s.left = l[mes_pkg::DIST_W-1:0];
      s.right = r[mes_pkg::DIST_W-1:0];
      sample_q.push_back(s);
      n_pushed++;
   endtask

   function automatic int unsigned rnd_dist();
      case ($urandom_range(5))
         0: return $urandom_range(thr);
         1: return $urandom_range(4095);
         2: return thr + $urandom_range(300);
         default: return $urandom_range(open_d + 100 > 4095 ? 4095 : open_d + 100);
      endcase
   endfunction

   // approach: optional open run, front shrinking one cell at a time, then a turn
   task automatic push_corridor();
      int unsigned n, f;
      n = $urandom_range(6, 1);
      f = (n + 1) * ((csz == 0) ? 1 : csz) + $urandom_range(20);
      if ($urandom_range(3) == 0) repeat ($urandom_range(12, 1))
         push(open_d + $urandom_range(4095 - (open_d > 4095 ? 4095 : open_d)),
              rnd_dist(), rnd_dist());
      repeat (n) begin
         f = (f > csz) ? f - csz : 0;
         push(f > 4095 ? 4095 : f, rnd_dist(), rnd_dist());
      end
      push($urandom_range(thr), rnd_dist(), rnd_dist());
   endtask

   // queue about count samples
   task automatic random_phase(int unsigned count);
      int unsigned stop_at;
      stop_at = n_pushed + count;
      while (n_pushed < stop_at) begin
         if ($urandom_range(9) < 7) push_corridor();
         else repeat (6) push($urandom_range(4095), $urandom_range(4095),
                              $urandom_range(4095));
      end
   endtask

   initial begin
      thr = mes_pkg::RST_WALL_THRESHOLD; csz = mes_pkg::RST_CELL_SIZE;
      fstep = mes_pkg::RST_FORWARD_STEP;
      open_d = mes_pkg::RST_OPEN_DISTANCE; climit = mes_pkg::RST_COUNT_LIMIT;
      for (int i = 0; i < NCELL; i++) begin
         seen[i] = 0;
         walls[i] = 4'hF;
      end
      seen[0] = 1;
      px = 0; py = 0; dir = 0; last_cells = 0; adv_cnt = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, each action, stop, grid edges
      push(4095, 4095, 4095);
      push(0, 0, 0);
      push(0, 4095, 0);
      push(0, 0, 4095);
      push(500, 0, 0);
      push(500, 300, 200);
      push(500, 200, 300);
      push(1266, 50, 50);
      push(1267, 50, 50);
      push(100, 101, 101);
      push(101, 100, 100);
      for (int i = 0; i < 10; i++) push(4095 - i, 2730, 1365);
      push(900, 0, 0);
      push(700, 0, 0);
      push(0, 4095, 4095);
      drain();

      // zero cell size, unknown index, extremes
      write_reg(mes_pkg::REG_CELL_SIZE, 0);
      write_reg(REG_UNUSED, 12'hABC);
      write_reg(mes_pkg::REG_FORWARD_STEP, 4095);
      random_phase(200);
      drain();

      write_reg(mes_pkg::REG_WALL_THRESHOLD, 0);
      write_reg(mes_pkg::REG_CELL_SIZE, 1);
      write_reg(mes_pkg::REG_FORWARD_STEP, 1);
      write_reg(mes_pkg::REG_OPEN_DISTANCE, 0);
      write_reg(mes_pkg::REG_COUNT_LIMIT, 0);
      random_phase(150);
      drain();

      write_reg(mes_pkg::REG_WALL_THRESHOLD, 4095);
      write_reg(mes_pkg::REG_CELL_SIZE, 4095);
      write_reg(mes_pkg::REG_OPEN_DISTANCE, 4095);
      write_reg(mes_pkg::REG_COUNT_LIMIT, 4095);
      random_phase(150);
      drain();

      // back to typical values; long stretch with no idling
      write_reg(mes_pkg::REG_WALL_THRESHOLD, 100);
      write_reg(mes_pkg::REG_CELL_SIZE, 180);
      write_reg(mes_pkg::REG_FORWARD_STEP, 20);
      write_reg(mes_pkg::REG_OPEN_DISTANCE, 1260);
      write_reg(mes_pkg::REG_COUNT_LIMIT, 1266);
      calm = 1'b1;
      random_phase(300);
      drain();
      calm = 1'b0;

      // random settings, with a pause of the sender until all words return
      repeat (4) begin
         write_reg(mes_pkg::REG_WALL_THRESHOLD, $urandom_range(400));
         write_reg(mes_pkg::REG_CELL_SIZE, $urandom_range(400, 40));
         write_reg(mes_pkg::REG_FORWARD_STEP, $urandom_range(200, 1));
         write_reg(mes_pkg::REG_OPEN_DISTANCE, $urandom_range(2000, 500));
         write_reg(mes_pkg::REG_COUNT_LIMIT, $urandom_range(4095));
         random_phase(130);
         repeat (400) @(posedge clock);
         hold_tx = 1'b1;
         while (decision_q.size() > 0 || req.valid) @(posedge clock);
         hold_tx = 1'b0;
         random_phase(130);
         drain();
      end

      if (errors == 0) begin
         $display("maze_explore_step_tb: PASS");
      end else begin
         $display("maze_explore_step_tb: FAIL");
      end
      $finish;
   end
endmodule
